// ----- rtl/ecd_pkg.sv -----
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared widths, codes and helper functions for the encoder step counter.
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int ENC_W       = 8;
  localparam int BTN_W       = 4;
  localparam int VAL_W       = 10;
  localparam int SEG_W       = 8;
  localparam int MODE_W      = 4;
  localparam int HIST_W      = 9;
  localparam int DIG_W       = 14;
  localparam int PIN_BUTTONS = 4;

  localparam logic [HIST_W-1:0] HIST_FIRE  = 9'h100;
  localparam logic [MODE_W-1:0] MODE_RESET = 4'b0010;
  localparam logic [MODE_W-1:0] MODE_STEP1 = 4'b0010;
  localparam logic [MODE_W-1:0] MODE_STEP2 = 4'b0100;
  localparam logic [MODE_W-1:0] MODE_STEP4 = 4'b1000;

  localparam logic [1:0] ENC_REST = 2'b11;
  localparam logic [1:0] ENC_UP   = 2'b01;
  localparam logic [1:0] ENC_DOWN = 2'b10;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    bcd_t             digit;
    logic [DIG_W-1:0] rest;
  } split_t;

  function automatic split_t split_digit(input logic [DIG_W-1:0] value, input int unit);
    split_t s;
    s.digit = '0;
    s.rest  = value;
    for (int k = 1; k < 10; k++) begin
      if (value >= DIG_W'(k * unit)) begin
        s.digit = 4'(k);
        s.rest  = value - DIG_W'(k * unit);
      end
    end
    return s;
  endfunction

  function automatic logic [SEG_W-1:0] seg_code(input bcd_t d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0: s = 8'hc0;
      4'd1: s = 8'hf9;
      4'd2: s = 8'ha4;
      4'd3: s = 8'hb0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hf8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h98;
      default: s = 8'hff;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/ecd_channels.sv -----
// ----------------------------------------------------------------------------
// ecd_channels
// Valid/ready channels for poll items and result items.
// ----------------------------------------------------------------------------
interface ecd_poll_if;
  import ecd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ENC_W-1:0] encoder_bits;
  logic [BTN_W-1:0] button_levels;

  modport source (output valid, output encoder_bits, output button_levels, input ready);
  modport sink   (input valid, input encoder_bits, input button_levels, output ready);
endinterface

interface ecd_result_if;
  import ecd_pkg::*;
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  count_value;
  logic [SEG_W-1:0]  seg_ones;
  logic [SEG_W-1:0]  seg_tens;
  logic [SEG_W-1:0]  seg_hundreds;
  logic [SEG_W-1:0]  seg_thousands;
  logic [MODE_W-1:0] mode_flags;

  modport source (output valid, output count_value, output seg_ones, output seg_tens,
                  output seg_hundreds, output seg_thousands, output mode_flags,
                  input ready);
  modport sink   (input valid, input count_value, input seg_ones, input seg_tens,
                  input seg_hundreds, input seg_thousands, input mode_flags,
                  output ready);
endinterface

// ----- rtl/ecd_front.sv -----
// ----------------------------------------------------------------------------
// ecd_front
// Accepts polls, debounces buttons, decodes encoder steps and updates the
// counter and mode bits.
// ----------------------------------------------------------------------------
module ecd_front #(
  parameter int NUM_BUTTONS = 4,
  parameter int COUNT_LIMIT = 1023,
  parameter int CNT_W       = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  ecd_poll_if.sink                          poll,
  output logic                              push,
  output logic [CNT_W+ecd_pkg::MODE_W-1:0]  push_data,
  input  logic                              push_ready
);
  import ecd_pkg::*;

  localparam logic [CNT_W:0]   LIMIT_EXT = (CNT_W+1)'(COUNT_LIMIT);
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(COUNT_LIMIT);

  logic [HIST_W-1:0] hist      [NUM_BUTTONS];
  logic [HIST_W-1:0] hist_next [NUM_BUTTONS];
  logic [1:0]        prev_a;
  logic [1:0]        prev_b;
  logic [1:0]        cur_a;
  logic [1:0]        cur_b;
  logic [MODE_W-1:0] mode;
  logic [MODE_W-1:0] mode_next;
  logic [MODE_W-1:0] fire;
  logic [CNT_W-1:0]  counter;
  logic [CNT_W-1:0]  counter_next;
  logic [CNT_W:0]    sum;
  logic [2:0]        step;
  logic              up_a, dn_a, up_b, dn_b, dir_up, dir_dn;
  logic              accept;

  assign poll.ready = push_ready;
  assign accept     = poll.valid && push_ready;

  assign cur_a  = poll.encoder_bits[1:0];
  assign cur_b  = poll.encoder_bits[3:2];
  assign up_a   = (prev_a == ENC_REST) && (cur_a == ENC_UP);
  assign dn_a   = (prev_a == ENC_REST) && (cur_a == ENC_DOWN);
  assign up_b   = (prev_b == ENC_REST) && (cur_b == ENC_UP);
  assign dn_b   = (prev_b == ENC_REST) && (cur_b == ENC_DOWN);
  assign dir_up = up_b || (up_a && !dn_b);
  assign dir_dn = dn_b || (dn_a && !up_b);

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_hist
    if (b < PIN_BUTTONS) begin : g_pin
      assign hist_next[b] = {hist[b][HIST_W-2:0], poll.button_levels[b]};
    end else begin : g_nopin
      assign hist_next[b] = {hist[b][HIST_W-2:0], 1'b1};
    end
  end

  for (genvar m = 0; m < MODE_W; m++) begin : g_fire
    if (m < NUM_BUTTONS) begin : g_btn
      assign fire[m] = (hist_next[m] == HIST_FIRE);
    end else begin : g_none
      assign fire[m] = 1'b0;
    end
  end

  assign mode_next = mode ^ fire;

  always_comb begin
    case (mode_next)
      MODE_STEP1: step = 3'd1;
      MODE_STEP2: step = 3'd2;
      MODE_STEP4: step = 3'd4;
      default:    step = 3'd0;
    endcase
  end

  assign sum = {1'b0, counter} + (CNT_W+1)'(step);

  always_comb begin
    if (dir_up) begin
      counter_next = (sum > LIMIT_EXT) ? CNT_W'(1) : sum[CNT_W-1:0];
    end else if (dir_dn) begin
      counter_next = (counter < CNT_W'(step)) ? LIMIT_CNT : counter - CNT_W'(step);
    end else begin
      counter_next = counter;
    end
  end

  assign push      = accept;
  assign push_data = {counter_next, mode_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        hist[b] <= '0;
      end
      prev_a  <= '0;
      prev_b  <= '0;
      mode    <= MODE_RESET;
      counter <= '0;
    end else if (accept) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        hist[b] <= hist_next[b];
      end
      prev_a  <= cur_a;
      prev_b  <= cur_b;
      mode    <= mode_next;
      counter <= counter_next;
    end
  end

endmodule

// ----- rtl/ecd_queue.sv -----
// ----------------------------------------------------------------------------
// ecd_queue
// Small first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module ecd_queue #(
  parameter int W     = 14,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  input  logic         pop_ready
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/ecd_back.sv -----
// ----------------------------------------------------------------------------
// ecd_back
// Splits the counter into decimal digits over two stages and registers the
// seven-segment result.
// ----------------------------------------------------------------------------
module ecd_back #(
  parameter int CNT_W = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [CNT_W+ecd_pkg::MODE_W-1:0] in_data,
  output logic                             in_ready,
  ecd_result_if.source                     result
);
  import ecd_pkg::*;

  logic [DIG_W-1:0]  in_val;
  logic [MODE_W-1:0] in_mode;
  split_t            sp3, sp2, sp1;

  logic              s1_valid;
  logic [DIG_W-1:0]  s1_val;
  bcd_t              s1_d3;
  logic [DIG_W-1:0]  s1_rest;
  logic [MODE_W-1:0] s1_mode;

  logic              s2_valid;
  logic [DIG_W-1:0]  s2_val;
  bcd_t              s2_d3;
  bcd_t              s2_d2;
  logic [DIG_W-1:0]  s2_rest;
  logic [MODE_W-1:0] s2_mode;

  logic              out_free, s2_free, s1_free;

  assign in_val  = DIG_W'(in_data[CNT_W+MODE_W-1:MODE_W]);
  assign in_mode = in_data[MODE_W-1:0];

  assign sp3 = split_digit(in_val, 1000);
  assign sp2 = split_digit(s1_rest, 100);
  assign sp1 = split_digit(s2_rest, 10);

  assign out_free = !result.valid || result.ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        result.valid <= s2_valid;
      end
    end
    if (s1_free && in_valid) begin
      s1_val  <= in_val;
      s1_d3   <= sp3.digit;
      s1_rest <= sp3.rest;
      s1_mode <= in_mode;
    end
    if (s2_free && s1_valid) begin
      s2_val  <= s1_val;
      s2_d3   <= s1_d3;
      s2_d2   <= sp2.digit;
      s2_rest <= sp2.rest;
      s2_mode <= s1_mode;
    end
    if (out_free && s2_valid) begin
      result.count_value   <= VAL_W'(s2_val);
      result.seg_ones      <= seg_code(sp1.rest[3:0]);
      result.seg_tens      <= seg_code(sp1.digit);
      result.seg_hundreds  <= seg_code(s2_d2);
      result.seg_thousands <= seg_code(s2_d3);
      result.mode_flags    <= s2_mode;
    end
  end

endmodule

// ----- rtl/encoder_step_counter_display_core.sv -----
// ----------------------------------------------------------------------------
// encoder_step_counter_display_core
// Rotary encoder step counter with debounced mode buttons and a four-digit
// seven-segment readout.
// ----------------------------------------------------------------------------
// Each item on the poll channel carries one encoder byte and four raw
// active-low button levels. The front part updates the debouncers, the mode
// bits and the counter in the cycle the item is accepted, and writes the new
// counter and mode into a two-entry queue. The back part splits the counter
// into decimal digits in two stages and registers the result item: the
// counter, four active-low segment bytes and the mode bits.
// One poll is accepted in every cycle while the result side keeps up.
// Reset clears the debouncers, encoder history and counter, sets the mode
// to 0010 and empties the queue and the digit pipeline.
// When the result receiver stalls, the digit pipeline and then the queue
// fill up; poll ready drops only after all of them are full, and no item is
// lost or repeated.
// ----------------------------------------------------------------------------
module encoder_step_counter_display_core #(
  parameter int NUM_BUTTONS = 4,
  parameter int COUNT_LIMIT = 1023
) (
  input  logic         clk,
  input  logic         rst,
  ecd_poll_if.sink     poll,
  ecd_result_if.source result
);
  import ecd_pkg::*;

  localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);
  localparam int QW          = CNT_W + MODE_W;
  localparam int QUEUE_DEPTH = 2;

  logic          push, push_ready;
  logic [QW-1:0] push_data;
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;

  ecd_front #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COUNT_LIMIT (COUNT_LIMIT),
    .CNT_W       (CNT_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .poll       (poll),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  ecd_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  ecd_back #(
    .CNT_W (CNT_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop_valid),
    .in_data  (pop_data),
    .in_ready (pop_ready),
    .result   (result)
  );

endmodule

// ----- rtl/ecd_checker.sv -----
// ----------------------------------------------------------------------------
// ecd_checker
// Port-level checks on the encoder step counter, bound to the top level.
// ----------------------------------------------------------------------------
module ecd_checker #(
  parameter int COUNT_LIMIT = 1023
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ecd_pkg::VAL_W-1:0]    count_value,
  input logic [ecd_pkg::SEG_W-1:0]    seg_ones,
  input logic [ecd_pkg::SEG_W-1:0]    seg_tens,
  input logic [ecd_pkg::SEG_W-1:0]    seg_hundreds,
  input logic [ecd_pkg::SEG_W-1:0]    seg_thousands,
  input logic [ecd_pkg::MODE_W-1:0]   mode_flags
);
  import ecd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count_value) && $stable(mode_flags))
    else $error("stalled result changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (COUNT_LIMIT > 1023) || (int'(count_value) <= COUNT_LIMIT))
    else $error("count above limit");

  a_zero_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid && count_value == '0 && COUNT_LIMIT < 1024 |->
      seg_ones == 8'hc0 && seg_tens == 8'hc0 && seg_hundreds == 8'hc0 &&
      seg_thousands == 8'hc0)
    else $error("zero count shows wrong digits");

endmodule

bind encoder_step_counter_display_core ecd_checker #(
  .COUNT_LIMIT (COUNT_LIMIT)
) u_ecd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (poll.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .count_value   (result.count_value),
  .seg_ones      (result.seg_ones),
  .seg_tens      (result.seg_tens),
  .seg_hundreds  (result.seg_hundreds),
  .seg_thousands (result.seg_thousands),
  .mode_flags    (result.mode_flags)
);

// ----- verif/encoder_step_counter_display_core_test.sv -----
// ----------------------------------------------------------------------------
// encoder_step_counter_display_core_test
// Self-checking bench for the encoder step counter. Polls with encoder detents,
// button presses and noise are sent on the poll channel. A scoreboard tracks
// debounce, mode and counter state, and compares every result item with its
// own prediction. Both channels idle at random, and the result side also
// holds off long enough for the poll side to stall.
// ----------------------------------------------------------------------------
module encoder_step_counter_display_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ecd_pkg::*;

  localparam int COUNT_TOP      = 1023;
  localparam int POLL_TARGET    = 1550;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int DRAIN_CYCLES   = 12;

  localparam logic [SEG_W-1:0] DIGIT_SEGMENTS [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h98
  };

  typedef struct {
    logic [VAL_W-1:0]  count;
    logic [SEG_W-1:0]  ones;
    logic [SEG_W-1:0]  tens;
    logic [SEG_W-1:0]  hundreds;
    logic [SEG_W-1:0]  thousands;
    logic [MODE_W-1:0] mode;
  } readout_t;

  class readout_board;
    logic [HIST_W-1:0] press_history [PIN_BUTTONS];
    logic [1:0]        last_pair [2];
    logic [MODE_W-1:0] mode;
    int                count;
    readout_t          pending_readouts [$];
    int                errors;

    function new();
      for (int b = 0; b < PIN_BUTTONS; b++) press_history[b] = '0;
      last_pair[0] = '0;
      last_pair[1] = '0;
      mode         = MODE_RESET;
      count        = 0;
      errors       = 0;
    endfunction

    function void take_poll(logic [ENC_W-1:0] enc, logic [BTN_W-1:0] levels);
      int         dir;
      int         stride;
      int         next;
      logic [1:0] cur;
      readout_t   r;
      dir = 0;
      for (int e = 0; e < 2; e++) begin
        cur = enc[2*e +: 2];
        if (last_pair[e] == ENC_REST) begin
          if (cur == ENC_UP) dir = 1;
          else if (cur == ENC_DOWN) dir = -1;
        end
        last_pair[e] = cur;
      end
      for (int b = 0; b < PIN_BUTTONS; b++) begin
        press_history[b] = {press_history[b][HIST_W-2:0], levels[b]};
        if (press_history[b] == HIST_FIRE) mode[b] = ~mode[b];
      end
      case (mode)
        MODE_STEP1: stride = 1;
        MODE_STEP2: stride = 2;
        MODE_STEP4: stride = 4;
        default:    stride = 0;
      endcase
      next = count + dir * stride;
      if (next > COUNT_TOP) next = 1;
      else if (next < 0) next = COUNT_TOP;
      count = next;
      r.count     = VAL_W'(count);
      r.ones      = DIGIT_SEGMENTS[count % 10];
      r.tens      = DIGIT_SEGMENTS[(count / 10) % 10];
      r.hundreds  = DIGIT_SEGMENTS[(count / 100) % 10];
      r.thousands = DIGIT_SEGMENTS[(count / 1000) % 10];
      r.mode      = mode;
      pending_readouts.push_back(r);
    endfunction

    task report(string field, int got, int want);
      $display("error at %0t: %s is %0h, expected %0h", $realtime, field, got, want);
      errors++;
    endtask

    task match_readout(readout_t got);
      readout_t want;
      if (pending_readouts.size() == 0) begin
        report("result item with nothing outstanding, count", got.count, 0);
      end else begin
        want = pending_readouts.pop_front();
        if (got.count !== want.count) report("count_value", got.count, want.count);
        if (got.ones !== want.ones) report("seg_ones", got.ones, want.ones);
        if (got.tens !== want.tens) report("seg_tens", got.tens, want.tens);
        if (got.hundreds !== want.hundreds) report("seg_hundreds", got.hundreds, want.hundreds);
        if (got.thousands !== want.thousands) begin
          report("seg_thousands", got.thousands, want.thousands);
        end
        if (got.mode !== want.mode) report("mode_flags", got.mode, want.mode);
      end
    endtask

    function int outstanding();
      return pending_readouts.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   polls_sent;
  int   results_seen;
  int   quiet_cycles;

  readout_board board;

  ecd_poll_if   poll_ch();
  ecd_result_if result_ch();

  encoder_step_counter_display_core uut (
    .clk   (clk),
    .rst   (rst),
    .poll  (poll_ch),
    .result(result_ch)
  );

  always #4 clk = ~clk;

  task automatic send_poll(input logic [ENC_W-1:0] enc, input logic [BTN_W-1:0] levels,
                           input bit eager = 1'b0);
    static int calm_left = 0;
    int        gap;
    if (calm_left == 0 && $urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    if (eager || calm_left > 0) begin
      gap = 0;
      if (calm_left > 0) calm_left--;
    end else begin
      gap = $urandom_range(0, 11);
    end
    @(negedge clk);
    if (gap > 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    poll_ch.valid         <= 1'b1;
    poll_ch.encoder_bits  <= enc;
    poll_ch.button_levels <= levels;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
    board.take_poll(enc, levels);
    polls_sent++;
  endtask

  function automatic logic [ENC_W-1:0] rest_code();
    return {4'($urandom_range(0, 15)), ENC_REST, ENC_REST};
  endfunction

  function automatic logic [1:0] pair_code();
    case ($urandom_range(0, 6))
      0, 1:    return ENC_UP;
      2, 3:    return ENC_DOWN;
      4:       return 2'b00;
      default: return ENC_REST;
    endcase
  endfunction

  function automatic logic [ENC_W-1:0] turn_code();
    return {4'($urandom_range(0, 15)), pair_code(), pair_code()};
  endfunction

  task automatic directed_polls();
    send_poll(8'h0F, 4'hF);
    send_poll(8'h0D, 4'hF);
    send_poll(8'h0F, 4'hF);
    send_poll(8'h0E, 4'hF);
    send_poll(8'h0F, 4'hF);
    send_poll(8'h0E, 4'hF);
    send_poll(8'h0F, 4'hF);
    send_poll(8'h0D, 4'hF);
    send_poll(8'h07, 4'hF);
    send_poll(8'hFF, 4'hF);
    send_poll(8'h09, 4'hF);
    send_poll(8'hF0, 4'h0);
    send_poll(8'h0F, 4'hF);
    for (int k = 0; k < 8; k++) send_poll((k % 2) ? 8'h0D : 8'h0F, 4'b1001);
    send_poll(8'h0F, 4'hF);
    send_poll(8'h0D, 4'hF);
    for (int k = 0; k < 8; k++) send_poll((k % 2) ? 8'h0E : 8'h0F, 4'b0011);
    send_poll(8'hAF, 4'hF);
    send_poll(8'h5E, 4'hF);
  endtask

  task automatic random_polls();
    logic [BTN_W-1:0]  mask;
    logic [MODE_W-1:0] target;
    int                pick;
    int                len;
    while (polls_sent < POLL_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_poll(rest_code(), 4'hF);
        send_poll(turn_code(), 4'hF);
      end else if (pick < 8) begin
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 2))
            0:       target = MODE_STEP1;
            1:       target = MODE_STEP2;
            default: target = MODE_STEP4;
          endcase
          mask = board.mode ^ target;
          if (mask == '0) mask = BTN_W'(1 << $urandom_range(0, 3));
        end else if ($urandom_range(0, 3) == 0) begin
          mask = BTN_W'($urandom_range(1, 15));
        end else begin
          mask = BTN_W'(1 << $urandom_range(0, 3));
        end
        send_poll(rest_code(), 4'hF);
        len = $urandom_range(6, 10);
        for (int k = 0; k < len; k++) begin
          send_poll((k % 2) ? turn_code() : rest_code(), ~mask);
        end
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          send_poll(ENC_W'($urandom_range(0, 255)), BTN_W'($urandom_range(0, 15)));
        end
      end
    end
  endtask

  initial begin
    readout_t got;
    int       gap;
    int       calm_left;
    calm_left       = 0;
    result_ch.ready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      if (calm_left == 0 && $urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
      if (results_seen == 300 || results_seen == 1100) begin
        gap = HOLD_CYCLES;
      end else if (calm_left > 0) begin
        gap = 0;
        calm_left--;
      end else begin
        gap = $urandom_range(0, 11);
      end
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      got.count     = result_ch.count_value;
      got.ones      = result_ch.seg_ones;
      got.tens      = result_ch.seg_tens;
      got.hundreds  = result_ch.seg_hundreds;
      got.thousands = result_ch.seg_thousands;
      got.mode      = result_ch.mode_flags;
      board.match_readout(got);
      results_seen++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    polls_sent            = 0;
    results_seen          = 0;
    quiet_cycles          = 0;
    poll_ch.valid         = 1'b0;
    poll_ch.encoder_bits  = '0;
    poll_ch.button_levels = '1;
    board                 = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    directed_polls();
    random_polls();
    @(negedge clk);
    poll_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
